/* design/tlp_pkg.sv */
package tlp_pkg;

  localparam int unsigned OutBytes = 7;

  // ASCII codes
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChV     = 8'h56;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChComma = 8'h2c;

  // Line positions
  localparam logic [4:0] PosMode     = 5'd0;
  localparam logic [4:0] PosOne      = 5'd1;
  localparam logic [4:0] PosDot      = 5'd2;
  localparam logic [4:0] PosVerFirst = 5'd3;
  localparam logic [4:0] PosVerLast  = 5'd4;
  localparam logic [4:0] PosSep0     = 5'd5;
  localparam logic [4:0] PosStmFirst = 5'd6;
  localparam logic [4:0] PosStmLast  = 5'd8;
  localparam logic [4:0] PosSep1     = 5'd9;
  localparam logic [4:0] PosTgtFirst = 5'd10;
  localparam logic [4:0] PosTgtLast  = 5'd12;
  localparam logic [4:0] PosSep2     = 5'd13;
  localparam logic [4:0] PosExcFirst = 5'd14;
  localparam logic [4:0] PosExcLast  = 5'd16;
  localparam logic [4:0] PosSep3     = 5'd17;
  localparam logic [4:0] PosCntFirst = 5'd18;
  localparam logic [4:0] PosCntLast  = 5'd21;
  localparam logic [4:0] PosSep4     = 5'd22;
  localparam logic [4:0] PosLast     = 5'd23;

  // Decoded record, packed so the last field sits in the lowest bits.
  typedef struct packed {
    logic        heater_active;
    logic [13:0] heat_countdown;
    logic [9:0]  exchanger_temperature;
    logic [9:0]  target_temperature;
    logic [9:0]  steam_temperature;
    logic [6:0]  fw_version;
    logic        mode_steam;
  } rec_t;

  localparam int unsigned RecWidth = $bits(rec_t);
  localparam int unsigned PadWidth = OutBytes * 8 - RecWidth;

  function automatic logic is_mode(logic [7:0] b);
    return (b == ChC) || (b == ChV);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  function automatic logic fits(logic [4:0] pos, logic [7:0] b);
    logic ok;
    unique case (pos)
      PosMode: ok = is_mode(b);
      PosOne:  ok = (b == ChOne);
      PosDot:  ok = (b == ChDot);
      PosSep0, PosSep1, PosSep2, PosSep3, PosSep4: ok = (b == ChComma);
      PosLast: ok = (b == ChZero) || (b == ChOne);
      default: ok = is_digit(b);
    endcase
    return ok;
  endfunction

  // acc * 10 + d, or d alone on the first digit of a field
  function automatic logic [13:0] acc_digit(logic [13:0] acc, logic [3:0] d, logic first);
    logic [13:0] base;
    base = first ? 14'd0 : ((acc << 3) + (acc << 1));
    return base + {10'd0, d};
  endfunction

endpackage

/* design/telemetry_line_parser.sv */
// Telemetry line parser: one received byte per transaction.
// A record is registered into the head entry on its final byte, or into the skid entry while the head is held.
// Throughput: one byte per cycle; a two-entry output buffer keeps the input
// open while one record waits; the input stalls only when both entries are full.
// Reset (rst_ni low, async): match position, mode and accumulators cleared,
// output buffer emptied.
module telemetry_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata_i: [7:0] rx_byte
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // m_axis_tdata_o: [0] mode_steam, [7:1] fw_version, [17:8] steam_temperature,
  // [27:18] target_temperature, [37:28] exchanger_temperature,
  // [51:38] heat_countdown, [52] heater_active, [55:53] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o
);

  // Match state
  logic [4:0]  pos_q, pos_d;
  logic        mode_q, mode_d;
  logic [6:0]  ver_q, ver_d;
  logic [9:0]  stm_q, stm_d;
  logic [9:0]  tgt_q, tgt_d;
  logic [9:0]  exc_q, exc_d;
  logic [13:0] cnt_q, cnt_d;

  // Output buffer: head entry drives the port, skid entry catches overflow
  tlp_pkg::rec_t head_q, skid_q, rec_new;
  logic          head_vld_q, skid_vld_q;

  logic       accept, emit, pop, fit;
  logic [4:0] pos;
  logic [7:0] b;
  logic [3:0] dig;

  assign b   = s_axis_tdata_i;
  assign dig = b[3:0];  // low nibble of an ASCII digit is its value

  assign s_axis_tready_o = !skid_vld_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = head_vld_q && m_axis_tready_i;

  // Out-of-range position restarts as position 0
  assign pos = (pos_q > tlp_pkg::PosLast) ? tlp_pkg::PosMode : pos_q;
  assign fit = tlp_pkg::fits(pos, b);

  always_comb begin
    pos_d = pos_q;
    mode_d = mode_q;
    ver_d = ver_q;
    stm_d = stm_q;
    tgt_d = tgt_q;
    exc_d = exc_q;
    cnt_d = cnt_q;
    emit = 1'b0;
    if (accept) begin
      if (!fit) begin
        // mismatch: a mode letter starts a new candidate line
        if (tlp_pkg::is_mode(b)) begin
          mode_d = (b == tlp_pkg::ChV);
          pos_d = tlp_pkg::PosOne;
        end else begin
          pos_d = tlp_pkg::PosMode;
        end
      end else begin
        pos_d = pos + 5'd1;
        priority if (pos == tlp_pkg::PosMode) begin
          mode_d = (b == tlp_pkg::ChV);
        end else if (pos >= tlp_pkg::PosVerFirst && pos <= tlp_pkg::PosVerLast) begin
          ver_d = 7'(tlp_pkg::acc_digit({7'd0, ver_q}, dig, pos == tlp_pkg::PosVerFirst));
        end else if (pos >= tlp_pkg::PosStmFirst && pos <= tlp_pkg::PosStmLast) begin
          stm_d = 10'(tlp_pkg::acc_digit({4'd0, stm_q}, dig, pos == tlp_pkg::PosStmFirst));
        end else if (pos >= tlp_pkg::PosTgtFirst && pos <= tlp_pkg::PosTgtLast) begin
          tgt_d = 10'(tlp_pkg::acc_digit({4'd0, tgt_q}, dig, pos == tlp_pkg::PosTgtFirst));
        end else if (pos >= tlp_pkg::PosExcFirst && pos <= tlp_pkg::PosExcLast) begin
          exc_d = 10'(tlp_pkg::acc_digit({4'd0, exc_q}, dig, pos == tlp_pkg::PosExcFirst));
        end else if (pos >= tlp_pkg::PosCntFirst && pos <= tlp_pkg::PosCntLast) begin
          cnt_d = tlp_pkg::acc_digit(cnt_q, dig, pos == tlp_pkg::PosCntFirst);
        end else if (pos == tlp_pkg::PosLast) begin
          // flag byte closes the line
          emit = 1'b1;
          pos_d = tlp_pkg::PosMode;
        end else begin
          // literal characters: only advance
        end
      end
    end
  end

  always_comb begin
    rec_new.mode_steam            = mode_q;
    rec_new.fw_version            = ver_q;
    rec_new.steam_temperature     = stm_q;
    rec_new.target_temperature    = tgt_q;
    rec_new.exchanger_temperature = exc_q;
    rec_new.heat_countdown        = cnt_q;
    rec_new.heater_active         = b[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mode_q <= 1'b0;
      ver_q  <= '0;
      stm_q  <= '0;
      tgt_q  <= '0;
      exc_q  <= '0;
      cnt_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      mode_q <= mode_d;
      ver_q  <= ver_d;
      stm_q  <= stm_d;
      tgt_q  <= tgt_d;
      exc_q  <= exc_d;
      cnt_q  <= cnt_d;
    end
  end

  // Buffer valid flags; a push never meets a full buffer since tready drops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        head_vld_q <= emit;
      end
    end else if (emit) begin
      if (head_vld_q) begin
        skid_vld_q <= 1'b1;
      end else begin
        head_vld_q <= 1'b1;
      end
    end
  end

  // Buffer payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        head_q <= skid_q;
      end else if (emit) begin
        head_q <= rec_new;
      end
    end else if (emit) begin
      if (head_vld_q) begin
        skid_q <= rec_new;
      end else begin
        head_q <= rec_new;
      end
    end
  end

  assign m_axis_tvalid_o = head_vld_q;
  assign m_axis_tdata_o  = {{tlp_pkg::PadWidth{1'b0}}, head_q};

endmodule
